FILE: sv/convex_hull_diameter_calipers_core_defines.svh
// ----------------------------------------------------------------------------
// convex hull diameter calipers - assertion macros
// shared property wrappers for the core's checks
// ----------------------------------------------------------------------------
`ifndef CONVEX_HULL_DIAMETER_CALIPERS_CORE_DEFINES_SVH
`define CONVEX_HULL_DIAMETER_CALIPERS_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define CHDC_ASSERT_IMPL(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define CHDC_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define CHDC_ASSERT_IMPL(lbl, pre, post)
`define CHDC_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

FILE: sv/chdc_pkg.sv
// ----------------------------------------------------------------------------
// chdc_pkg
// constants, command and status types shared by the calipers core
// ----------------------------------------------------------------------------
package chdc_pkg;

    localparam int MAX_VERTICES   = 1024;
    localparam int COORD_BITS     = 12;
    localparam int ADDR_BITS      = $clog2(MAX_VERTICES);
    localparam int CNT_BITS       = ADDR_BITS + 1;
    localparam int POINT_BITS     = 2 * COORD_BITS;
    localparam int SQ_BITS        = 2 * COORD_BITS + 1;
    localparam int SQRT_STEPS     = (SQ_BITS + 1) / 2;
    localparam int SQRT_CNT_BITS  = $clog2(SQRT_STEPS);
    localparam int OUT_COORD_BITS = 12;
    localparam int DSQ_BITS       = 25;
    localparam int DFL_BITS       = 13;
    localparam longint DSQ_MAX    = (64'd1 << DSQ_BITS) - 64'd1;
    localparam longint DFL_MAX    = (64'd1 << DFL_BITS) - 64'd1;

    localparam logic [1:0] RD_J  = 2'd0;
    localparam logic [1:0] RD_I  = 2'd1;
    localparam logic [1:0] RD_IP = 2'd2;
    localparam logic [1:0] RD_JN = 2'd3;

    typedef struct packed {
        logic       load;
        logic       start;
        logic [1:0] rd_sel;
        logic       lat_pj;
        logic       lat_pi;
        logic       lat_pip;
        logic       mul;
        logic       adv;
        logic       sq1;
        logic       sq2;
        logic       upd;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic n_lt2;
        logic steps_done;
        logic cross_pos;
        logic last_edge;
        logic sqrt_last;
        logic out_busy;
    } stat_t;

endpackage

FILE: sv/convex_hull_diameter_calipers_core.sv
// sequence: the vertices are loaded, then setup, then for each edge the caliper steps and two
// squared distances are compared, then the square root, then the output register, which
// waits while the previous word is still held
// throughput: one polygon at a time; the single read port of the vertex store sets the pace
// reset: rst_n asynchronous active low clears the sequencer, vertex count and output valid
// ----------------------------------------------------------------------------
// convex_hull_diameter_calipers_core
// diameter of a convex polygon by rotating calipers, one word per vertex
// ----------------------------------------------------------------------------
`include "convex_hull_diameter_calipers_core_defines.svh"

module convex_hull_diameter_calipers_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [11:0] vertex_x,
    input  logic [11:0] vertex_y,
    input  logic        last_vertex,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic [11:0] first_x,
    output logic [11:0] first_y,
    output logic [11:0] second_x,
    output logic [11:0] second_y,
    output logic [24:0] diameter_sq,
    output logic [12:0] diameter_floor
);

    chdc_pkg::cmd_t  cmd;
    chdc_pkg::stat_t stat;

    chdc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .last_vertex (last_vertex),
        .in_stall    (in_stall),
        .stat        (stat),
        .cmd         (cmd)
    );

    chdc_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .vertex_x       (vertex_x),
        .vertex_y       (vertex_y),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .first_x        (first_x),
        .first_y        (first_y),
        .second_x       (second_x),
        .second_y       (second_y),
        .diameter_sq    (diameter_sq),
        .diameter_floor (diameter_floor)
    );

    `CHDC_ASSERT_IMPL(a_err_zero, out_valid && status, (diameter_sq == 25'd0) && (first_x == 12'd0))
    `CHDC_ASSERT_IMPL(a_floor_low, out_valid && !status, (27'(diameter_floor) * 27'(diameter_floor)) <= 27'(diameter_sq))
    `CHDC_ASSERT_IMPL(a_floor_high, out_valid && !status, ((27'(diameter_floor) + 27'd1) * (27'(diameter_floor) + 27'd1)) > 27'(diameter_sq))
    `CHDC_ASSERT_NEXT(a_no_input_in_pass, in_valid && !in_stall && last_vertex, in_stall)

endmodule

FILE: sv/chdc_ram.sv
// ----------------------------------------------------------------------------
// chdc_ram
// generic simple dual port ram with registered read
// ----------------------------------------------------------------------------
module chdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/chdc_ctrl.sv
// ----------------------------------------------------------------------------
// chdc_ctrl
// sequencer for load, caliper pass, square root and result hand-off
// ----------------------------------------------------------------------------
module chdc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            last_vertex,
    output logic            in_stall,
    input  chdc_pkg::stat_t stat,
    output chdc_pkg::cmd_t  cmd
);

    localparam logic [3:0] S_LOAD = 4'd0;
    localparam logic [3:0] S_CHK  = 4'd1;
    localparam logic [3:0] S_J0   = 4'd2;
    localparam logic [3:0] S_J0L  = 4'd3;
    localparam logic [3:0] S_I    = 4'd4;
    localparam logic [3:0] S_IP   = 4'd5;
    localparam logic [3:0] S_PIP  = 4'd6;
    localparam logic [3:0] S_RJ   = 4'd7;
    localparam logic [3:0] S_M    = 4'd8;
    localparam logic [3:0] S_C    = 4'd9;
    localparam logic [3:0] S_D1   = 4'd10;
    localparam logic [3:0] S_D2   = 4'd11;
    localparam logic [3:0] S_D3   = 4'd12;
    localparam logic [3:0] S_SQI  = 4'd13;
    localparam logic [3:0] S_SQS  = 4'd14;
    localparam logic [3:0] S_OUT  = 4'd15;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_stall = (state_reg != S_LOAD);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = chdc_pkg::RD_J;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (last_vertex)
                    begin
                        state_next = S_CHK;
                    end
                end
            end
            S_CHK:
            begin
                if (stat.n_lt2)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    state_next = S_J0;
                end
            end
            S_J0:
            begin
                cmd.rd_sel = chdc_pkg::RD_J;
                state_next = S_J0L;
            end
            S_J0L:
            begin
                cmd.lat_pj = 1'b1;
                state_next = S_I;
            end
            S_I:
            begin
                cmd.rd_sel = chdc_pkg::RD_I;
                state_next = S_IP;
            end
            S_IP:
            begin
                cmd.lat_pi = 1'b1;
                cmd.rd_sel = chdc_pkg::RD_IP;
                state_next = S_PIP;
            end
            S_PIP:
            begin
                cmd.lat_pip = 1'b1;
                state_next  = S_RJ;
            end
            S_RJ:
            begin
                cmd.rd_sel = chdc_pkg::RD_JN;
                state_next = stat.steps_done ? S_D1 : S_M;
            end
            S_M:
            begin
                cmd.mul    = 1'b1;
                state_next = S_C;
            end
            S_C:
            begin
                if (stat.cross_pos)
                begin
                    cmd.adv    = 1'b1;
                    state_next = S_RJ;
                end
                else
                begin
                    state_next = S_D1;
                end
            end
            S_D1:
            begin
                cmd.sq1    = 1'b1;
                state_next = S_D2;
            end
            S_D2:
            begin
                cmd.sq2    = 1'b1;
                state_next = S_D3;
            end
            S_D3:
            begin
                cmd.upd    = 1'b1;
                state_next = stat.last_edge ? S_SQI : S_I;
            end
            S_SQI:
            begin
                cmd.sqrt_init = 1'b1;
                state_next    = S_SQS;
            end
            S_SQS:
            begin
                cmd.sqrt_step = 1'b1;
                if (stat.sqrt_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: sv/chdc_dpath.sv
// ----------------------------------------------------------------------------
// chdc_dpath
// vertex store, caliper arithmetic, best pair and bitwise square root
// ----------------------------------------------------------------------------
module chdc_dpath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  chdc_pkg::cmd_t                         cmd,
    output chdc_pkg::stat_t                        stat,
    input  logic [11:0]                            vertex_x,
    input  logic [11:0]                            vertex_y,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   status,
    output logic [chdc_pkg::OUT_COORD_BITS-1:0]    first_x,
    output logic [chdc_pkg::OUT_COORD_BITS-1:0]    first_y,
    output logic [chdc_pkg::OUT_COORD_BITS-1:0]    second_x,
    output logic [chdc_pkg::OUT_COORD_BITS-1:0]    second_y,
    output logic [chdc_pkg::DSQ_BITS-1:0]          diameter_sq,
    output logic [chdc_pkg::DFL_BITS-1:0]          diameter_floor
);

    localparam int CB = chdc_pkg::COORD_BITS;
    localparam int AB = chdc_pkg::ADDR_BITS;
    localparam int NB = chdc_pkg::CNT_BITS;
    localparam int QB = chdc_pkg::SQ_BITS;
    localparam int PB = 2 * CB + 2;

    logic [NB-1:0] count_reg;
    logic [AB-1:0] i_reg;
    logic [AB-1:0] j_reg;
    logic [NB-1:0] steps_reg;
    logic [CB-1:0] pi_x_reg, pi_y_reg, pip_x_reg, pip_y_reg;
    logic [CB-1:0] pj_x_reg, pj_y_reg, pjn_x_reg, pjn_y_reg;
    logic signed [PB-1:0] prod_a_reg, prod_b_reg;
    logic [2*CB-1:0] sqa_reg, sqb_reg;
    logic [QB-1:0]   d1_reg;
    logic [QB-1:0]   best_sq_reg;
    logic [CB-1:0]   bf_x_reg, bf_y_reg, bs_x_reg, bs_y_reg;
    logic [QB-1:0]   v_reg;
    logic [QB-1:0]   res_reg;
    logic [chdc_pkg::SQRT_CNT_BITS-1:0] k_reg;
    logic            out_valid_reg;

    logic [AB-1:0]   raddr;
    logic [chdc_pkg::POINT_BITS-1:0] rdata;
    logic [CB-1:0]   rd_x, rd_y;
    logic            we;
    logic [NB-1:0]   i_inc, j_inc;
    logic [AB-1:0]   ip, jn;

    logic signed [CB:0]   ux, uy, djx, djy, dx, dy;
    logic signed [PB-1:0] crs;
    logic signed [2*CB+1:0] sq_x, sq_y;
    logic [QB-1:0]   d2;
    logic [QB:0]     trial, sbit;
    logic [31:0]     bsq32;

    chdc_ram #(
        .WIDTH (chdc_pkg::POINT_BITS),
        .DEPTH (chdc_pkg::MAX_VERTICES)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[AB-1:0]),
        .wdata ({CB'(vertex_x), CB'(vertex_y)}),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_x  = rdata[2*CB-1:CB];
    assign rd_y  = rdata[CB-1:0];
    assign we    = cmd.load && (count_reg < NB'(chdc_pkg::MAX_VERTICES));
    assign i_inc = NB'(i_reg) + NB'(1);
    assign j_inc = NB'(j_reg) + NB'(1);
    assign ip    = (i_inc == count_reg) ? '0 : i_inc[AB-1:0];
    assign jn    = (j_inc == count_reg) ? '0 : j_inc[AB-1:0];

    always_comb
    begin
        unique case (cmd.rd_sel)
            chdc_pkg::RD_J:  raddr = j_reg;
            chdc_pkg::RD_I:  raddr = i_reg;
            chdc_pkg::RD_IP: raddr = ip;
            chdc_pkg::RD_JN: raddr = jn;
            default:         raddr = j_reg;
        endcase
    end

    // edge vector against the step from j to j+1
    assign ux  = $signed({1'b0, pip_x_reg}) - $signed({1'b0, pi_x_reg});
    assign uy  = $signed({1'b0, pip_y_reg}) - $signed({1'b0, pi_y_reg});
    assign djx = $signed({1'b0, rd_x}) - $signed({1'b0, pj_x_reg});
    assign djy = $signed({1'b0, rd_y}) - $signed({1'b0, pj_y_reg});
    assign crs = prod_a_reg - prod_b_reg;

    assign dx   = cmd.sq1 ? ($signed({1'b0, pj_x_reg}) - $signed({1'b0, pi_x_reg}))
                          : ($signed({1'b0, pj_x_reg}) - $signed({1'b0, pip_x_reg}));
    assign dy   = cmd.sq1 ? ($signed({1'b0, pj_y_reg}) - $signed({1'b0, pi_y_reg}))
                          : ($signed({1'b0, pj_y_reg}) - $signed({1'b0, pip_y_reg}));
    assign sq_x = dx * dx;
    assign sq_y = dy * dy;
    assign d2   = QB'(sqa_reg) + QB'(sqb_reg);

    assign sbit  = (QB + 1)'(1) << (2 * k_reg);
    assign trial = (QB + 1)'(res_reg) + sbit;
    assign bsq32 = 32'(best_sq_reg);

    assign stat.n_lt2      = (count_reg < NB'(2));
    assign stat.steps_done = (steps_reg == count_reg);
    assign stat.cross_pos  = (crs > 0);
    assign stat.last_edge  = (i_inc == count_reg);
    assign stat.sqrt_last  = (k_reg == '0);
    assign stat.out_busy   = out_valid_reg;
    assign out_valid       = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                count_reg <= count_reg + NB'(1);
            end
            else if (cmd.out_load)
            begin
                count_reg <= '0;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            i_reg       <= '0;
            j_reg       <= AB'(1);
            steps_reg   <= '0;
            best_sq_reg <= '0;
        end
        if (cmd.lat_pj)
        begin
            pj_x_reg <= rd_x;
            pj_y_reg <= rd_y;
        end
        if (cmd.lat_pi)
        begin
            pi_x_reg <= rd_x;
            pi_y_reg <= rd_y;
            // degenerate polygon reports vertex 0 twice
            if (i_reg == '0)
            begin
                bf_x_reg <= rd_x;
                bf_y_reg <= rd_y;
                bs_x_reg <= rd_x;
                bs_y_reg <= rd_y;
            end
        end
        if (cmd.lat_pip)
        begin
            pip_x_reg <= rd_x;
            pip_y_reg <= rd_y;
        end
        if (cmd.mul)
        begin
            pjn_x_reg  <= rd_x;
            pjn_y_reg  <= rd_y;
            prod_a_reg <= ux * djy;
            prod_b_reg <= uy * djx;
        end
        if (cmd.adv)
        begin
            j_reg     <= jn;
            pj_x_reg  <= pjn_x_reg;
            pj_y_reg  <= pjn_y_reg;
            steps_reg <= steps_reg + NB'(1);
        end
        if (cmd.sq1 || cmd.sq2)
        begin
            sqa_reg <= sq_x[2*CB-1:0];
            sqb_reg <= sq_y[2*CB-1:0];
        end
        if (cmd.sq2)
        begin
            d1_reg <= d2;
        end
        if (cmd.upd)
        begin
            if (d1_reg > d2)
            begin
                if (best_sq_reg < d1_reg)
                begin
                    best_sq_reg <= d1_reg;
                    bf_x_reg    <= pj_x_reg;
                    bf_y_reg    <= pj_y_reg;
                    bs_x_reg    <= pi_x_reg;
                    bs_y_reg    <= pi_y_reg;
                end
            end
            else if (best_sq_reg < d2)
            begin
                best_sq_reg <= d2;
                bf_x_reg    <= pj_x_reg;
                bf_y_reg    <= pj_y_reg;
                bs_x_reg    <= pip_x_reg;
                bs_y_reg    <= pip_y_reg;
            end
            i_reg     <= ip;
            steps_reg <= '0;
        end
        if (cmd.sqrt_init)
        begin
            v_reg   <= best_sq_reg;
            res_reg <= '0;
            k_reg   <= chdc_pkg::SQRT_CNT_BITS'(chdc_pkg::SQRT_STEPS - 1);
        end
        if (cmd.sqrt_step)
        begin
            if ((QB + 1)'(v_reg) >= trial)
            begin
                v_reg   <= v_reg - QB'(trial);
                res_reg <= (res_reg >> 1) + QB'(sbit);
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            k_reg <= k_reg - chdc_pkg::SQRT_CNT_BITS'(1);
        end
        if (cmd.out_load)
        begin
            if (stat.n_lt2)
            begin
                status         <= 1'b1;
                first_x        <= '0;
                first_y        <= '0;
                second_x       <= '0;
                second_y       <= '0;
                diameter_sq    <= '0;
                diameter_floor <= '0;
            end
            else
            begin
                status         <= 1'b0;
                first_x        <= chdc_pkg::OUT_COORD_BITS'(bf_x_reg);
                first_y        <= chdc_pkg::OUT_COORD_BITS'(bf_y_reg);
                second_x       <= chdc_pkg::OUT_COORD_BITS'(bs_x_reg);
                second_y       <= chdc_pkg::OUT_COORD_BITS'(bs_y_reg);
                diameter_sq    <= (bsq32 > 32'(chdc_pkg::DSQ_MAX))
                                  ? chdc_pkg::DSQ_BITS'(chdc_pkg::DSQ_MAX)
                                  : chdc_pkg::DSQ_BITS'(bsq32);
                diameter_floor <= (32'(res_reg) > 32'(chdc_pkg::DFL_MAX))
                                  ? chdc_pkg::DFL_BITS'(chdc_pkg::DFL_MAX)
                                  : chdc_pkg::DFL_BITS'(res_reg);
            end
        end
    end

endmodule
